// ===== rtl/brse_pkg.sv =====
package brse_pkg;

	// fixed field widths
	localparam int OFF_W  = 48;
	localparam int ENT_W  = 5;
	localparam int STAT_W = 2;
	localparam int REQ_W  = 2;

	// default table size
	localparam int DEFAULT_TABLE_DEPTH = 16;

	// request codes
	localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_MERGE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

	// operation applied to every cell in a cycle
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_LOAD,
		OP_SORT,
		OP_APPLY,
		OP_COMPACT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     parity;
	} cell_ctrl_t;

endpackage

// ===== rtl/byte_range_set_engine_unit.sv =====
// channel   signals                                              direction
// command   start, busy, req_type, first_offset, last_offset,    in (start & !busy)
//           probe_offset
// result    done, status, inside_res, entries                    out (one cycle)
//
// add and unused codes: result in the cycle after the transaction, busy stays low
// query: the hit bit walks down the cell row before the result
// consolidate: sort rounds, wave steps,
//   one apply step, then compaction rounds across the cell row
// reset clears the entry count and control; the result strobe is never held
module byte_range_set_engine_unit import brse_pkg::*; #(
	parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [REQ_W-1:0]  req_type,
	input  logic [OFF_W-1:0]  first_offset,
	input  logic [OFF_W-1:0]  last_offset,
	input  logic [OFF_W-1:0]  probe_offset,
	output logic              done,
	output logic [STAT_W-1:0] status,
	output logic              inside_res,
	output logic [ENT_W-1:0]  entries
);

	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int STEP_W = $clog2(2 * TABLE_DEPTH);
	localparam logic [STEP_W-1:0] STEP_ROUND_END = STEP_W'(TABLE_DEPTH - 1);
	localparam logic [STEP_W-1:0] STEP_QUERY_END = STEP_W'(TABLE_DEPTH);
	localparam logic [STEP_W-1:0] STEP_WAVE_END  = STEP_W'(2 * TABLE_DEPTH - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_QUERY,
		S_SORT,
		S_WAVE,
		S_APPLY,
		S_COMPACT
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0]  count_q, new_count_q;
	logic [OFF_W-1:0]  probe_q;
	logic              done_q, inside_q;
	logic [STAT_W-1:0] status_q;
	logic [ENT_W-1:0]  entries_q;

	logic       accept, add_ok, full;
	cell_ctrl_t ctrl;

	logic [OFF_W-1:0] c_first  [TABLE_DEPTH];
	logic [OFF_W-1:0] c_last   [TABLE_DEPTH];
	logic [OFF_W-1:0] c_runmax [TABLE_DEPTH];
	logic [OFF_W-1:0] c_gmax   [TABLE_DEPTH];
	logic [CNT_W-1:0] c_cnt    [TABLE_DEPTH];
	logic             c_hit    [TABLE_DEPTH];
	logic             c_dead   [TABLE_DEPTH];
	logic             c_valid  [TABLE_DEPTH];

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign full   = (count_q == CNT_W'(TABLE_DEPTH));
	assign add_ok = !(last_offset < first_offset) && !full;

	// per-cycle operation for the cell row
	always_comb begin
		ctrl.op     = OP_HOLD;
		ctrl.parity = step_q[0];
		unique case (state_q)
			S_IDLE: begin
				if (accept && (req_type == REQ_ADD) && add_ok) begin
					ctrl.op = OP_LOAD;
				end
			end
			S_SORT:    ctrl.op = OP_SORT;
			S_APPLY:   ctrl.op = OP_APPLY;
			S_COMPACT: ctrl.op = OP_COMPACT;
			default:   ctrl.op = OP_HOLD;
		endcase
	end

	// row of cells, each talking only to its neighbors
	for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
		logic             lv, rv, lh, ld, rd;
		logic [OFF_W-1:0] lf, ll, lr, rf, rl, rg;
		logic [CNT_W-1:0] lc;

		assign c_valid[k] = (CNT_W'(k) < count_q);

		if (k == 0) begin : g_head
			assign lv = 1'b0;
			assign lf = '0;
			assign ll = '0;
			assign lr = '0;
			assign lc = '0;
			assign lh = 1'b0;
			assign ld = 1'b0;
		end else begin : g_mid_l
			assign lv = c_valid[k-1];
			assign lf = c_first[k-1];
			assign ll = c_last[k-1];
			assign lr = c_runmax[k-1];
			assign lc = c_cnt[k-1];
			assign lh = c_hit[k-1];
			assign ld = c_dead[k-1];
		end

		if (k == TABLE_DEPTH - 1) begin : g_tail
			assign rv = 1'b0;
			assign rf = '0;
			assign rl = '0;
			assign rg = '0;
			assign rd = 1'b0;
		end else begin : g_mid_r
			assign rv = c_valid[k+1];
			assign rf = c_first[k+1];
			assign rl = c_last[k+1];
			assign rg = c_gmax[k+1];
			assign rd = c_dead[k+1];
		end

		brse_cell #(
			.IDX   (k),
			.CNT_W (CNT_W)
		) u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.load_en     (count_q == CNT_W'(k)),
			.new_first   (first_offset),
			.new_last    (last_offset),
			.probe       (probe_q),
			.valid_self  (c_valid[k]),
			.left_valid  (lv),
			.left_first  (lf),
			.left_last   (ll),
			.left_runmax (lr),
			.left_cnt    (lc),
			.left_hit    (lh),
			.left_dead   (ld),
			.right_valid (rv),
			.right_first (rf),
			.right_last  (rl),
			.right_gmax  (rg),
			.right_dead  (rd),
			.first       (c_first[k]),
			.last        (c_last[k]),
			.runmax      (c_runmax[k]),
			.gmax        (c_gmax[k]),
			.cnt         (c_cnt[k]),
			.hit         (c_hit[k]),
			.dead        (c_dead[k])
		);
	end

	// sequencer and registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			count_q     <= '0;
			new_count_q <= '0;
			done_q      <= 1'b0;
			probe_q     <= '0;
			status_q    <= ST_OK;
			inside_q    <= 1'b0;
			entries_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					step_q <= '0;
					if (accept) begin
						probe_q  <= probe_offset;
						status_q <= ST_OK;
						inside_q <= 1'b0;
						case (req_type)
							REQ_ADD: begin
								done_q <= 1'b1;
								if (last_offset < first_offset) begin
									status_q  <= ST_INVALID;
									entries_q <= ENT_W'(count_q);
								end else if (full) begin
									status_q  <= ST_FULL;
									entries_q <= ENT_W'(count_q);
								end else begin
									count_q   <= count_q + 1'b1;
									entries_q <= ENT_W'(count_q + 1'b1);
								end
							end
							REQ_MERGE: state_q <= S_SORT;
							REQ_QUERY: state_q <= S_QUERY;
							default: begin
								done_q    <= 1'b1;
								entries_q <= ENT_W'(count_q);
							end
						endcase
					end
				end
				S_QUERY: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_QUERY_END) begin
						state_q   <= S_IDLE;
						done_q    <= 1'b1;
						status_q  <= ST_OK;
						inside_q  <= (count_q == '0) || c_hit[TABLE_DEPTH-1];
						entries_q <= ENT_W'(count_q);
					end
				end
				S_SORT: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_ROUND_END) begin
						state_q <= S_WAVE;
						step_q  <= '0;
					end
				end
				S_WAVE: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_WAVE_END) begin
						state_q <= S_APPLY;
						step_q  <= '0;
					end
				end
				S_APPLY: begin
					new_count_q <= c_cnt[TABLE_DEPTH-1];
					state_q     <= S_COMPACT;
					step_q      <= '0;
				end
				S_COMPACT: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_ROUND_END) begin
						state_q   <= S_IDLE;
						count_q   <= new_count_q;
						done_q    <= 1'b1;
						status_q  <= ST_OK;
						inside_q  <= 1'b0;
						entries_q <= ENT_W'(new_count_q);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign inside_res = inside_q;
	assign entries    = entries_q;

`ifndef SYNTHESIS
	// a result only follows a transaction or the end of a busy stretch
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || start))
		else $error("result strobe without a transaction");

	// the entry count holds while a query or the merge front end runs
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_QUERY || state_q == S_SORT || state_q == S_WAVE) |=> $stable(count_q))
		else $error("entry count changed during a long operation");

	// merging never grows the table
	a_merge_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APPLY) |=> (new_count_q <= $past(count_q)))
		else $error("merged count exceeds table count");

	// an empty table always reports a hit on a query
	a_empty_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(state_q == S_QUERY) && (count_q == '0)) |-> inside_res)
		else $error("query on empty table missed");
`endif

endmodule

// ===== rtl/brse_cell.sv =====
module brse_cell import brse_pkg::*; #(
	parameter int IDX   = 0,
	parameter int CNT_W = 5
) (
	input  logic             clk,
	input  cell_ctrl_t       ctrl,
	input  logic             load_en,
	input  logic [OFF_W-1:0] new_first,
	input  logic [OFF_W-1:0] new_last,
	input  logic [OFF_W-1:0] probe,
	input  logic             valid_self,
	input  logic             left_valid,
	input  logic [OFF_W-1:0] left_first,
	input  logic [OFF_W-1:0] left_last,
	input  logic [OFF_W-1:0] left_runmax,
	input  logic [CNT_W-1:0] left_cnt,
	input  logic             left_hit,
	input  logic             left_dead,
	input  logic             right_valid,
	input  logic [OFF_W-1:0] right_first,
	input  logic [OFF_W-1:0] right_last,
	input  logic [OFF_W-1:0] right_gmax,
	input  logic             right_dead,
	output logic [OFF_W-1:0] first,
	output logic [OFF_W-1:0] last,
	output logic [OFF_W-1:0] runmax,
	output logic [OFF_W-1:0] gmax,
	output logic [CNT_W-1:0] cnt,
	output logic             hit,
	output logic             dead
);

	localparam logic IDX_ODD = ((IDX % 2) == 1);

	logic [OFF_W-1:0] first_q, last_q, runmax_q, gmax_q;
	logic [CNT_W-1:0] cnt_q;
	logic             hit_q, dead_q;

	logic             start_self, start_right;
	logic [OFF_W-1:0] runmax_d, gmax_d;
	logic             pair_r, both_r, both_l;
	logic             sw_r, sw_l;

	// group boundaries of the sorted table
	assign start_self  = valid_self && (!left_valid || (first_q > left_runmax));
	assign start_right = right_valid && (right_first > runmax_q);

	// running maximum of last offsets, carried from the left
	always_comb begin
		if (!valid_self) begin
			runmax_d = left_runmax;
		end else if (left_valid && (left_runmax > last_q)) begin
			runmax_d = left_runmax;
		end else begin
			runmax_d = last_q;
		end
	end

	// group maximum, carried from the right until the group ends
	assign gmax_d = (right_valid && !start_right) ? right_gmax : runmax_q;

	// wave registers relax every cycle toward their settled values
	always_ff @(posedge clk) begin
		runmax_q <= runmax_d;
		gmax_q   <= gmax_d;
		cnt_q    <= left_cnt + CNT_W'(start_self);
		hit_q    <= left_hit | (valid_self && (probe >= first_q) && (probe <= last_q));
	end

	// neighbor pairing for the transposition rounds
	assign pair_r = (ctrl.parity == IDX_ODD);
	assign both_r = valid_self && right_valid;
	assign both_l = left_valid && valid_self;

	always_comb begin
		sw_r = 1'b0;
		sw_l = 1'b0;
		case (ctrl.op)
			OP_SORT: begin
				sw_r = pair_r && both_r && (first_q > right_first);
				sw_l = !pair_r && both_l && (left_first > first_q);
			end
			OP_COMPACT: begin
				sw_r = pair_r && both_r && dead_q && !right_dead;
				sw_l = !pair_r && both_l && left_dead && !dead_q;
			end
			default: begin
				sw_r = 1'b0;
				sw_l = 1'b0;
			end
		endcase
	end

	// entry registers
	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_LOAD: begin
				if (load_en) begin
					first_q <= new_first;
					last_q  <= new_last;
				end
			end
			OP_SORT, OP_COMPACT: begin
				if (sw_r) begin
					first_q <= right_first;
					last_q  <= right_last;
					dead_q  <= right_dead;
				end else if (sw_l) begin
					first_q <= left_first;
					last_q  <= left_last;
					dead_q  <= left_dead;
				end
			end
			OP_APPLY: begin
				last_q <= gmax_q;
				dead_q <= !start_self;
			end
			default: begin
			end
		endcase
	end

	assign first  = first_q;
	assign last   = last_q;
	assign runmax = runmax_q;
	assign gmax   = gmax_q;
	assign cnt    = cnt_q;
	assign hit    = hit_q;
	assign dead   = dead_q;

endmodule

// ===== test/range_table_checker.sv =====
module range_table_checker import brse_pkg::*; #(
	parameter int DEPTH = DEFAULT_TABLE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic [REQ_W-1:0]  req_type,
	input  logic [OFF_W-1:0]  first_offset,
	input  logic [OFF_W-1:0]  last_offset,
	input  logic [OFF_W-1:0]  probe_offset,
	input  logic              done,
	input  logic [STAT_W-1:0] status,
	input  logic              inside_res,
	input  logic [ENT_W-1:0]  entries,
	output int                fail_count,
	output int                pending
);

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic              hit;
		logic [ENT_W-1:0]  entries;
	} outcome_t;

	// shadow of the range table
	logic [OFF_W-1:0] range_lo [DEPTH];
	logic [OFF_W-1:0] range_hi [DEPTH];
	int               held;

	// outcomes still owed by the block, oldest first
	outcome_t outcome_q [$];
	outcome_t want_res;

	initial fail_count = 0;

	task automatic report_mismatch(string what);
		fail_count++;
		$display("%0t: range table mismatch: %s", $time, what);
	endtask

	// stable bubble sort by first offset, then fold overlapping neighbors
	function automatic void consolidate_table();
		logic [OFF_W-1:0] t_lo, t_hi;
		int w;
		for (int p = 0; p + 1 < held; p++) begin
			for (int k = 0; k + 1 < held - p; k++) begin
				if (range_lo[k] > range_lo[k+1]) begin
					t_lo = range_lo[k];
					t_hi = range_hi[k];
					range_lo[k] = range_lo[k+1];
					range_hi[k] = range_hi[k+1];
					range_lo[k+1] = t_lo;
					range_hi[k+1] = t_hi;
				end
			end
		end
		if (held == 0)
			return;
		w = 0;
		for (int k = 1; k < held; k++) begin
			if (range_hi[w] >= range_lo[k]) begin
				if (range_hi[w] < range_hi[k])
					range_hi[w] = range_hi[k];
			end else begin
				w++;
				range_lo[w] = range_lo[k];
				range_hi[w] = range_hi[k];
			end
		end
		held = w + 1;
	endfunction

	// an empty table counts as a hit
	function automatic logic offset_covered(logic [OFF_W-1:0] at);
		if (held == 0)
			return 1'b1;
		for (int k = 0; k < held; k++) begin
			if (at >= range_lo[k] && at <= range_hi[k])
				return 1'b1;
		end
		return 1'b0;
	endfunction

	// update the shadow table and work out the outcome of one request
	function automatic outcome_t apply_request(logic [REQ_W-1:0] req,
			logic [OFF_W-1:0] lo, logic [OFF_W-1:0] hi, logic [OFF_W-1:0] at);
		outcome_t res;
		res.status = ST_OK;
		res.hit = 1'b0;
		case (req)
			REQ_ADD: begin
				if (hi < lo) begin
					res.status = ST_INVALID;
				end else if (held >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					range_lo[held] = lo;
					range_hi[held] = hi;
					held++;
				end
			end
			REQ_MERGE: consolidate_table();
			REQ_QUERY: res.hit = offset_covered(at);
			default: ;
		endcase
		res.entries = held[ENT_W-1:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held = 0;
			outcome_q.delete();
			pending <= 0;
		end else begin
			// result transaction against the oldest outcome
			if (done === 1'b1) begin
				if (outcome_q.size() == 0) begin
					report_mismatch($sformatf("result with nothing owed (status %0d entries %0d)",
						status, entries));
				end else begin
					want_res = outcome_q.pop_front();
					if (status !== want_res.status)
						report_mismatch($sformatf("status %0d, want %0d", status, want_res.status));
					if (inside_res !== want_res.hit)
						report_mismatch($sformatf("inside_res %0b, want %0b", inside_res,
							want_res.hit));
					if (entries !== want_res.entries)
						report_mismatch($sformatf("entries %0d, want %0d", entries,
							want_res.entries));
				end
			end
			// command transaction
			if (start === 1'b1 && busy === 1'b0)
				outcome_q.push_back(apply_request(req_type, first_offset, last_offset,
					probe_offset));
			pending <= outcome_q.size();
		end
	end

endmodule

// ===== test/byte_range_set_engine_unit_test.sv =====
module byte_range_set_engine_unit_test;
	import brse_pkg::*;

	localparam int DEPTH = DEFAULT_TABLE_DEPTH;
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam logic [OFF_W-1:0] OFF_MAX = '1;
	localparam int ITEM_TARGET = 1100;
	localparam int CALM_FROM = 950;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL = 4 * DEPTH + 8;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [REQ_W-1:0]  req_type = REQ_ADD;
	logic [OFF_W-1:0]  first_offset = '0;
	logic [OFF_W-1:0]  last_offset = '0;
	logic [OFF_W-1:0]  probe_offset = '0;
	logic              done;
	logic [STAT_W-1:0] status;
	logic              inside_res;
	logic [ENT_W-1:0]  entries;

	int fail_count;
	int pending;
	int items_sent = 0;
	int cycles = 0;
	int held_now = 0;
	bit gappy = 1'b0;

	// offset window of the current episode; zero span means the whole space
	logic [OFF_W-1:0] win_base = '0;
	int               win_span = 0;
	logic [OFF_W-1:0] recent_lo [$];
	logic [OFF_W-1:0] recent_hi [$];

	always #6 clk = ~clk;

	byte_range_set_engine_unit #(.TABLE_DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.first_offset(first_offset),
		.last_offset(last_offset),
		.probe_offset(probe_offset),
		.done(done),
		.status(status),
		.inside_res(inside_res),
		.entries(entries)
	);

	range_table_checker #(.DEPTH(DEPTH)) table_chk (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.first_offset(first_offset),
		.last_offset(last_offset),
		.probe_offset(probe_offset),
		.done(done),
		.status(status),
		.inside_res(inside_res),
		.entries(entries),
		.fail_count(fail_count),
		.pending(pending)
	);

	// table occupancy as last reported, steers the episode mix
	always @(posedge clk) begin
		if (done === 1'b1)
			held_now <= int'(entries);
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("byte_range_set_engine_unit regression: fail");
			$finish;
		end
	end

	function automatic logic [OFF_W-1:0] rand_off();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[OFF_W-1:0];
	endfunction

	function automatic logic [OFF_W-1:0] in_window();
		if (win_span == 0)
			return rand_off();
		return win_base + OFF_W'($urandom_range(0, win_span - 1));
	endfunction

	// half the time a recent range edge when there is one, so hits and misses both show up
	function automatic logic [OFF_W-1:0] pick_probe();
		int k;
		if (recent_lo.size() != 0 && $urandom_range(0, 1) == 0) begin
			k = $urandom_range(0, recent_lo.size() - 1);
			case ($urandom_range(0, 3))
				0: return recent_lo[k] - 1;
				1: return recent_lo[k];
				2: return recent_hi[k];
				default: return recent_hi[k] + 1;
			endcase
		end
		if ($urandom_range(0, 1) == 0)
			return in_window();
		return rand_off();
	endfunction

	// one command transaction, with an optional idle burst ahead of it
	task automatic issue(input logic [REQ_W-1:0] req, input logic [OFF_W-1:0] lo, hi, at);
		if (gappy && items_sent < CALM_FROM && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		start <= 1'b1;
		req_type <= req;
		first_offset <= lo;
		last_offset <= hi;
		probe_offset <= at;
		@(posedge clk);
		while (busy) @(posedge clk);
		items_sent++;
	endtask

	// hold off until every owed result is back
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic random_query();
		issue(REQ_QUERY, rand_off(), rand_off(), pick_probe());
	endtask

	task automatic random_add();
		logic [OFF_W-1:0] lo, hi, tmp;
		lo = in_window();
		case ($urandom_range(0, 3))
			0: hi = lo;
			1: hi = in_window();
			default: hi = lo + OFF_W'($urandom_range(0,
				(win_span == 0) ? 32'hffff : win_span / 4));
		endcase
		if (hi < lo) begin
			tmp = lo;
			lo = hi;
			hi = tmp;
		end
		if (recent_lo.size() >= 8) begin
			void'(recent_lo.pop_front());
			void'(recent_hi.pop_front());
		end
		recent_lo.push_back(lo);
		recent_hi.push_back(hi);
		// some inverted ranges
		if (lo != hi && $urandom_range(0, 7) == 0) begin
			tmp = lo;
			lo = hi;
			hi = tmp;
		end
		issue(REQ_ADD, lo, hi, rand_off());
	endtask

	// a burst of adds and queries in one window, usually closed by a consolidate;
	// a table at least half full (and sometimes any table) gets a covering range first so a consolidate collapses it
	task automatic run_episode();
		bit umbrella;
		int n_add;
		drain();
		umbrella = (held_now >= DEPTH / 2) || ($urandom_range(0, 5) == 0);
		gappy = ($urandom_range(0, 2) != 0);
		case ($urandom_range(0, 5))
			0: begin
				win_base = '0;
				win_span = 4096;
			end
			1: begin
				win_base = OFF_MAX - 4095;
				win_span = 4096;
			end
			2: begin
				win_base = '0;
				win_span = 0;
			end
			default: begin
				win_base = rand_off() & ~48'hffff;
				win_span = $urandom_range(0, 1) ? 4096 : 65536;
			end
		endcase
		recent_lo.delete();
		recent_hi.delete();
		if (umbrella) begin
			issue(REQ_ADD, OFF_W'($urandom_range(0, 3)),
				OFF_MAX - OFF_W'($urandom_range(0, 3)), rand_off());
			n_add = $urandom_range(1, DEPTH + 4);
		end else begin
			n_add = $urandom_range(1, DEPTH - 1 - held_now);
		end
		repeat (n_add) begin
			random_add();
			if ($urandom_range(0, 2) == 0)
				random_query();
			if ($urandom_range(0, 39) == 0)
				issue(REQ_UNUSED, rand_off(), rand_off(), rand_off());
		end
		if (umbrella || $urandom_range(0, 3) != 0) begin
			issue(REQ_MERGE, rand_off(), rand_off(), rand_off());
			if ($urandom_range(0, 7) == 0)
				issue(REQ_MERGE, rand_off(), rand_off(), rand_off());
		end
		repeat ($urandom_range(1, 4)) random_query();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table: query hits, consolidate is a no-op, unused code
		issue(REQ_QUERY, '0, '0, '0);
		issue(REQ_MERGE, OFF_MAX, OFF_MAX, OFF_MAX);
		issue(REQ_UNUSED, OFF_MAX, '0, OFF_MAX);
		// inverted ranges at both ends of the offset space
		issue(REQ_ADD, 48'd1, '0, '0);
		issue(REQ_ADD, OFF_MAX, OFF_MAX - 1, '0);
		// single offsets at the extremes, then a miss between them and a hit on the top one
		issue(REQ_ADD, '0, '0, '0);
		issue(REQ_ADD, OFF_MAX, OFF_MAX, '0);
		issue(REQ_QUERY, '0, '0, 48'd1);
		issue(REQ_QUERY, '0, '0, OFF_MAX);
		// fill to capacity with overlapping ranges, pairs sharing a first offset
		for (int i = 2; i < DEPTH; i++)
			issue(REQ_ADD, OFF_W'((i / 2) * 64 + 1),
				OFF_W'((i / 2) * 64 + 65 + (i % 3) * 40), '0);
		issue(REQ_ADD, '0, OFF_MAX, '0);
		issue(REQ_ADD, 48'd5, 48'd4, '0);
		issue(REQ_MERGE, '0, '0, '0);
		issue(REQ_QUERY, '0, '0, 48'd200);
		issue(REQ_QUERY, '0, '0, OFF_MAX - 1);

		while (items_sent < ITEM_TARGET)
			run_episode();

		drain();
		repeat (TAIL) @(posedge clk);
		if (fail_count == 0)
			$display("byte_range_set_engine_unit regression: pass");
		else
			$display("byte_range_set_engine_unit regression: fail");
		$finish;
	end

endmodule
